// File: sv/prdf_pkg.sv
// ----------------------------------------------------------------------------
// prdf_pkg: shared types and constants of the Pollard rho divisor finder
// Holds default widths, the step limit and the controller/datapath command set.
// ----------------------------------------------------------------------------
`default_nettype none
package prdf_pkg;
  localparam int unsigned NumberBitsDefault = 63;
  localparam int unsigned StepLimit = 1000000;
  localparam int unsigned StepCntBits = 20;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_REDUCE = 3'd2,
    CMD_MULX  = 3'd3,
    CMD_MULY  = 3'd4,
    CMD_GCD   = 3'd5
  } cmd_e;

  // which value the result carries
  typedef enum logic [1:0] {
    SEL_ONE    = 2'd0,
    SEL_TWO    = 2'd1,
    SEL_GCD    = 2'd2,
    SEL_NUMBER = 2'd3
  } res_sel_e;

  typedef struct packed {
    cmd_e cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // multi-cycle unit running
    logic n_one;
    logic n_even;
    logic d_one;     // gcd result equals one
  } dp_stat_t;
endpackage
`default_nettype wire

// File: sv/prdf_datapath.sv
// ----------------------------------------------------------------------------
// prdf_datapath: walk registers and shared bit-serial arithmetic
// One shared unit runs mod reduction (restoring, one bit a cycle), modular
// product (one multiplier bit a cycle) and binary gcd (one step a cycle).
// ----------------------------------------------------------------------------
`default_nettype none
module prdf_datapath #(
  parameter int unsigned NumberBits = prdf_pkg::NumberBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic [62:0]           number_i,
  input  wire logic [62:0]           start_value_i,
  input  wire logic [62:0]           increment_i,
  input  prdf_pkg::dp_cmd_t          cmd_i,
  output prdf_pkg::dp_stat_t         stat_o,
  output logic [NumberBits-1:0]      n_o,
  output logic [NumberBits-1:0]      d_o
);
  localparam int unsigned W = NumberBits;
  localparam int unsigned RawBits = 63;
  localparam int unsigned RcBits = $clog2(RawBits);

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001, U_RED = 6'b000010, U_MUL = 6'b000100,
    U_ADDC = 6'b001000, U_GCD = 6'b010000, U_GSH = 6'b100000
  } unit_e;

  logic [W-1:0] n_q, x_q, y_q, c_q, d_q;
  logic [W-1:0] acc_q, a_q, b_q;  // product / gcd operands
  logic [W-1:0] rem_q;
  logic [RawBits-1:0] sv_q;       // raw start value during reduction
  logic [RawBits-1:0] iv_q;       // raw increment during reduction
  logic         red_sel_q;        // 0: start, 1: increment
  logic         mul_y_q;
  logic [RcBits-1:0] rcnt_q;
  unit_e        u_q;

  assign n_o = n_q;
  assign d_o = d_q;

  // mod add of two residues: one wide add and compare
  function automatic logic [W-1:0] addm(logic [W-1:0] p, logic [W-1:0] q, logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic [W:0] rem_sh;
  logic [W-1:0] red_nxt;
  logic [RawBits-1:0] src_bit_vec;
  assign src_bit_vec = red_sel_q ? iv_q : sv_q;
  assign rem_sh = {rem_q, src_bit_vec[rcnt_q - RcBits'(1)]};
  assign red_nxt = (rem_sh >= {1'b0, n_q}) ? W'(rem_sh - {1'b0, n_q}) : rem_sh[W-1:0];

  logic [W-1:0] diff;
  assign diff = (x_q >= y_q) ? x_q - y_q : y_q - x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= U_IDLE;
    end else begin
      unique case (u_q)
        U_IDLE: begin
          unique case (cmd_i.cmd)
            prdf_pkg::CMD_REDUCE: u_q <= U_RED;
            prdf_pkg::CMD_MULX,
            prdf_pkg::CMD_MULY:   u_q <= U_MUL;
            prdf_pkg::CMD_GCD:    u_q <= U_GCD;
            default:              u_q <= U_IDLE;
          endcase
        end
        U_RED:  if (rcnt_q == RcBits'(1) && red_sel_q) u_q <= U_IDLE;
        U_MUL:  if (b_q == '0) u_q <= U_ADDC;
        U_ADDC: u_q <= U_IDLE;
        U_GCD:  if (b_q == '0) u_q <= U_GSH;
        U_GSH:  u_q <= U_IDLE;
        default: u_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      n_q <= number_i[W-1:0];
      sv_q <= start_value_i;
      iv_q <= increment_i;
    end
    unique case (u_q)
      U_IDLE: begin
        unique case (cmd_i.cmd)
          prdf_pkg::CMD_REDUCE: begin
            rem_q <= '0; rcnt_q <= RcBits'(RawBits); red_sel_q <= 1'b0;
          end
          prdf_pkg::CMD_MULX: begin
            acc_q <= '0; a_q <= x_q; b_q <= x_q; mul_y_q <= 1'b0;
          end
          prdf_pkg::CMD_MULY: begin
            acc_q <= '0; a_q <= y_q; b_q <= y_q; mul_y_q <= 1'b1;
          end
          prdf_pkg::CMD_GCD: begin
            // binary gcd: n odd, so a common power of two never arises
            a_q <= n_q; b_q <= diff;
          end
          default: ;
        endcase
      end
      U_RED: begin
        if (rcnt_q == RcBits'(1)) begin
          if (!red_sel_q) begin
            x_q <= red_nxt;
            y_q <= red_nxt;
            red_sel_q <= 1'b1; rem_q <= '0; rcnt_q <= RcBits'(RawBits);
          end else begin
            c_q <= red_nxt;
            rem_q <= red_nxt;
          end
        end else begin
          rem_q <= red_nxt;
          rcnt_q <= rcnt_q - RcBits'(1);
        end
      end
      U_MUL: begin
        if (b_q != '0) begin
          if (b_q[0]) acc_q <= addm(acc_q, a_q, n_q);
          a_q <= addm(a_q, a_q, n_q);
          b_q <= b_q >> 1;
        end
      end
      U_ADDC: begin
        if (mul_y_q) y_q <= addm(acc_q, c_q, n_q);
        else         x_q <= addm(acc_q, c_q, n_q);
      end
      U_GCD: begin
        // a stays odd; strip twos from b, then subtract
        if (b_q != '0) begin
          if (!b_q[0]) b_q <= b_q >> 1;
          else if (a_q > b_q) begin a_q <= b_q; b_q <= a_q - b_q; end
          else b_q <= b_q - a_q;
        end
      end
      U_GSH: d_q <= a_q;
      default: ;
    endcase
  end

  assign stat_o.busy   = (u_q != U_IDLE) || (cmd_i.cmd != prdf_pkg::CMD_NONE &&
                         cmd_i.cmd != prdf_pkg::CMD_LOAD);
  assign stat_o.n_one  = (n_q == W'(1));
  assign stat_o.n_even = ~n_q[0];
  assign stat_o.d_one  = (d_q == W'(1));
endmodule
`default_nettype wire

// File: sv/prdf_ctrl.sv
// ----------------------------------------------------------------------------
// prdf_ctrl: walk sequencer
// Issues one reduce per item, then three products and a gcd per step; counts
// steps; owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module prdf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                load_o,
  output prdf_pkg::dp_cmd_t   cmd_o,
  input  prdf_pkg::dp_stat_t  stat_i,
  output prdf_pkg::res_sel_e  res_sel_o
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_CHK  = 8'b00000010, S_RED  = 8'b00000100,
    S_MX   = 8'b00001000, S_MY1  = 8'b00010000, S_MY2  = 8'b00100000,
    S_GCD  = 8'b01000000, S_OUT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [prdf_pkg::StepCntBits-1:0] step_q, step_d;
  prdf_pkg::res_sel_e sel_q, sel_d;
  logic issued_q, issued_d;
  prdf_pkg::cmd_e cmd;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign load_o      = (state_q == S_IDLE) && in_valid_i;
  assign res_sel_o   = sel_q;
  assign cmd_o.cmd   = cmd;

  always_comb begin
    state_d = state_q; step_d = step_q; sel_d = sel_q; issued_d = issued_q;
    cmd = prdf_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CHK;
      S_CHK: begin
        step_d = '0;
        if (stat_i.n_one) begin sel_d = prdf_pkg::SEL_ONE; state_d = S_OUT; end
        else if (stat_i.n_even) begin sel_d = prdf_pkg::SEL_TWO; state_d = S_OUT; end
        else begin cmd = prdf_pkg::CMD_REDUCE; issued_d = 1'b1; state_d = S_RED; end
      end
      S_RED, S_MX, S_MY1, S_MY2, S_GCD: begin
        if (!issued_q) begin
          issued_d = 1'b1;
          unique case (state_q)
            S_MX:  cmd = prdf_pkg::CMD_MULX;
            S_MY1, S_MY2: cmd = prdf_pkg::CMD_MULY;
            S_GCD: cmd = prdf_pkg::CMD_GCD;
            default: cmd = prdf_pkg::CMD_NONE;
          endcase
        end else if (!stat_i.busy) begin
          issued_d = 1'b0;
          unique case (state_q)
            S_RED: begin
              if (step_q == prdf_pkg::StepCntBits'(prdf_pkg::StepLimit)) begin
                sel_d = prdf_pkg::SEL_NUMBER; state_d = S_OUT;
              end else begin
                step_d = step_q + prdf_pkg::StepCntBits'(1); state_d = S_MX;
              end
            end
            S_MX:  state_d = S_MY1;
            S_MY1: state_d = S_MY2;
            S_MY2: state_d = S_GCD;
            default: begin
              if (stat_i.d_one) state_d = S_RED;
              else begin sel_d = prdf_pkg::SEL_GCD; state_d = S_OUT; end
            end
          endcase
        end
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // S_RED doubles as the step-limit check after the first pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; step_q <= '0; sel_q <= prdf_pkg::SEL_ONE; issued_q <= 1'b0;
    end else begin
      state_q <= state_d; step_q <= step_d; sel_q <= sel_d;
      // after the first reduce, loop back to S_RED without reissuing
      if (state_q == S_GCD && state_d == S_RED) issued_q <= 1'b1;
      else issued_q <= issued_d;
    end
  end
endmodule
`default_nettype wire

// File: sv/pollard_rho_divisor_finder.sv
// ----------------------------------------------------------------------------
// pollard_rho_divisor_finder: Pollard rho divisor search, Floyd cycle check
// Controller sequencing a bit-serial modular datapath.
// ----------------------------------------------------------------------------
// Takes {number, start_value, increment} and returns one {divisor, failed}.
// Number one gives 1, an even number gives 2 (failed when number is 2).
// Otherwise the walk x -> x*x+c mod n runs with the hare at twice the speed
// and a gcd per step; a divisor equal to number, or a walk of one million steps,
// raises failed. One item at a time. Number one or an even number is answered
// straight from the check state. An odd number first has its start value and
// increment reduced mod n; each walk step then runs its three modular products
// in a shared shift-and-add unit and a binary gcd.
`default_nettype none
module pollard_rho_divisor_finder #(
  parameter int unsigned NumberBits = prdf_pkg::NumberBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [62:0] number_i,
  input  wire logic [62:0] start_value_i,
  input  wire logic [62:0] increment_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [62:0]      divisor_o,
  output logic             failed_o
);
  prdf_pkg::dp_cmd_t  cmd;
  prdf_pkg::dp_stat_t stat;
  logic load;
  prdf_pkg::res_sel_e sel;
  logic [NumberBits-1:0] n, d, res;

  prdf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .load_o(load), .cmd_o(cmd), .stat_i(stat), .res_sel_o(sel)
  );

  prdf_datapath #(.NumberBits(NumberBits)) u_dp (
    .clk_i, .rst_ni, .load_i(load), .number_i, .start_value_i, .increment_i,
    .cmd_i(cmd), .stat_o(stat), .n_o(n), .d_o(d)
  );

  // pick the answer by how the search ended
  always_comb begin
    unique case (sel)
      prdf_pkg::SEL_ONE: res = NumberBits'(1);
      prdf_pkg::SEL_TWO: res = NumberBits'(2);
      prdf_pkg::SEL_GCD: res = d;
      default:           res = n;
    endcase
  end

  assign divisor_o = 63'(res);
  assign failed_o  = (res == n) && (n > NumberBits'(1));
endmodule
`default_nettype wire
